FILE: rtl/spm_pkg.sv
// shared widths, constants and types of the stereo peak and rms meter
`timescale 1ns / 1ps
`default_nettype none
package spm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LVL_W         = 16;
    localparam int COEF_W        = 25;
    localparam int Q_FRAC        = 24;
    localparam int SUM_W         = 43;
    localparam int BLOCK_MAX_DEF = 4096;

    localparam logic [COEF_W-1:0] Q24_ONE       = COEF_W'(1) << Q_FRAC;
    localparam logic [COEF_W-1:0] RMS_COEFF_RST = COEF_W'(16776051);
    localparam logic [COEF_W-1:0] PEAK_DECAY_RST = COEF_W'(16768827);

    // configuration register indexes
    localparam logic CFG_RMS_COEFF  = 1'b0;
    localparam logic CFG_PEAK_DECAY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_L,
        ST_SQ_R,
        ST_PW_D,
        ST_PW_R,
        ST_CHECK,
        ST_PK_L,
        ST_PK_R,
        ST_PK_DONE,
        ST_RMS_GO,
        ST_RMS_WAIT,
        ST_RMS_MA,
        ST_RMS_MB,
        ST_RMS_SUM,
        ST_OUT
    } spm_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT,
        DS_DONE
    } spm_ds_state_t;

    // result of the divide and square root unit
    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] root;
    } spm_ds_result_t;

endpackage
`default_nettype wire

FILE: rtl/spm_divsqrt.sv
// iterative mean and floor square root unit: sum / n, then isqrt of the quotient
`timescale 1ns / 1ps
`default_nettype none
module spm_divsqrt #(
    parameter int DIV_W = 13
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [spm_pkg::SUM_W-1:0]  dividend,
    input  wire logic [DIV_W-1:0]           divisor,
    output spm_pkg::spm_ds_result_t         result
);

    localparam int SUM_W  = spm_pkg::SUM_W;
    localparam int LVL_W  = spm_pkg::LVL_W;
    localparam int RAD_W  = 2 * LVL_W;
    localparam int SREM_W = LVL_W + 2;
    localparam int STEP_W = $clog2(SUM_W);

    spm_pkg::spm_ds_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  drem_reg, drem_next;
    logic [DIV_W-1:0]  dvsr_reg, dvsr_next;
    logic [SREM_W-1:0] srem_reg, srem_next;
    logic [LVL_W-1:0]  root_reg, root_next;

    logic [DIV_W:0]    rem_ext;
    logic              div_take;
    logic [SREM_W+1:0] s_ext;
    logic [SREM_W+1:0] trial;
    logic              sq_take;

    always_comb
    begin
        rem_ext  = {drem_reg, quo_reg[SUM_W-1]};
        div_take = (rem_ext >= {1'b0, dvsr_reg});
        s_ext    = {srem_reg, quo_reg[RAD_W-1:RAD_W-2]};
        trial    = (SREM_W+2)'({root_reg, 2'b01});
        sq_take  = (s_ext >= trial);
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        drem_next  = drem_reg;
        dvsr_next  = dvsr_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        unique case (state_reg)
            spm_pkg::DS_IDLE:
            begin
                if (start)
                begin
                    quo_next   = dividend;
                    drem_next  = '0;
                    dvsr_next  = divisor;
                    step_next  = '0;
                    state_next = spm_pkg::DS_DIV;
                end
            end
            spm_pkg::DS_DIV:
            begin
                // one quotient bit a cycle, restoring
                quo_next  = {quo_reg[SUM_W-2:0], div_take};
                drem_next = div_take ? DIV_W'(rem_ext - {1'b0, dvsr_reg})
                                     : rem_ext[DIV_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    step_next  = '0;
                    srem_next  = '0;
                    root_next  = '0;
                    state_next = spm_pkg::DS_SQRT;
                end
            end
            spm_pkg::DS_SQRT:
            begin
                // one root bit a cycle, two radicand bits shifted in
                quo_next  = {quo_reg[SUM_W-3:0], 2'b00};
                srem_next = sq_take ? SREM_W'(s_ext - trial) : SREM_W'(s_ext);
                root_next = {root_reg[LVL_W-2:0], sq_take};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(LVL_W - 1))
                begin
                    state_next = spm_pkg::DS_DONE;
                end
            end
            spm_pkg::DS_DONE:
            begin
                state_next = spm_pkg::DS_IDLE;
            end
            default:
            begin
                state_next = spm_pkg::DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spm_pkg::DS_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        drem_reg <= drem_next;
        dvsr_reg <= dvsr_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign result.done = (state_reg == spm_pkg::DS_DONE);
    assign result.root = root_reg;

endmodule
`default_nettype wire

FILE: rtl/stereo_peak_rms_meter.sv
// top level of the stereo peak and rms level meter
//
//  channel | dir | handshake          | word
//  s_      | in  | s_tvalid/s_tready  | tdata {sample_right, sample_left}, tlast block_end
//  m_      | out | m_tvalid/m_tready  | tdata {rms_r, rms_l, peak_r, peak_l}
//  cfg_    | in  | cfg_we (no wait)   | cfg_index, cfg_data (q1.24 coefficient)
//
//  an open-block frame is an accept plus five shared multiplier steps;
//  a closing frame adds three peak steps, then per channel a start, 43 divider steps,
//  16 root steps, done and three rms multiplier steps, and at the end one load
//  rst_n clears the levels and block accumulators and restores default coefficients
//  a result waits in the output register while the next frames are taken;
//  only the following block close waits for m_tready
`timescale 1ns / 1ps
`default_nettype none
module stereo_peak_rms_meter #(
    parameter int BLOCK_MAX = spm_pkg::BLOCK_MAX_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input frames
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,  // sample_left[15:0], sample_right[31:16]
    input  wire logic                        s_tlast,  // block_end
    // results
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [63:0]                      m_tdata,  // peak_l, peak_r, rms_l, rms_r, 16 each
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [spm_pkg::COEF_W-1:0]  cfg_data
);

    localparam int LVL_W  = spm_pkg::LVL_W;
    localparam int COEF_W = spm_pkg::COEF_W;
    localparam int Q_FRAC = spm_pkg::Q_FRAC;
    localparam int SUM_W  = spm_pkg::SUM_W;
    localparam int SMP_W  = spm_pkg::SAMPLE_W;
    localparam int PROD_W = 2 * COEF_W;
    localparam int ACC_W  = Q_FRAC + LVL_W;
    localparam int CNT_W  = $clog2(BLOCK_MAX + 1);

    // sequencer and frame capture
    spm_pkg::spm_state_t state_reg, state_next;
    logic [LVL_W-1:0]  mag_l_reg, mag_l_next;
    logic [LVL_W-1:0]  mag_r_reg, mag_r_next;
    logic              last_reg, last_next;
    logic              ch_reg, ch_next;

    // block accumulators
    logic [LVL_W-1:0]  blk_pk_l_reg, blk_pk_l_next;
    logic [LVL_W-1:0]  blk_pk_r_reg, blk_pk_r_next;
    logic [SUM_W-1:0]  sum_l_reg, sum_l_next;
    logic [SUM_W-1:0]  sum_r_reg, sum_r_next;
    logic [CNT_W-1:0]  frames_reg, frames_next;
    logic [COEF_W-1:0] dpow_reg, dpow_next;
    logic [COEF_W-1:0] rpow_reg, rpow_next;

    // reported levels
    logic [LVL_W-1:0]  held_l_reg, held_l_next;
    logic [LVL_W-1:0]  held_r_reg, held_r_next;
    logic [LVL_W-1:0]  smooth_l_reg, smooth_l_next;
    logic [LVL_W-1:0]  smooth_r_reg, smooth_r_next;

    // coefficients
    logic [COEF_W-1:0] rms_coeff_reg, rms_coeff_next;
    logic [COEF_W-1:0] peak_decay_reg, peak_decay_next;

    // shared multiplier and its product register
    logic [COEF_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W:0]    acc_sum;
    logic [LVL_W-1:0]  decayed;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_data_reg, out_data_next;

    // divide and square root unit
    logic                    ds_start;
    logic [SUM_W-1:0]        ds_dividend;
    spm_pkg::spm_ds_result_t ds_result;

    // magnitude of a signed sample, most negative value gives 0x8000
    function automatic logic [LVL_W-1:0] magnitude(input logic [SMP_W-1:0] s);
        magnitude = s[SMP_W-1] ? LVL_W'(~s + SMP_W'(1)) : LVL_W'(s);
    endfunction

    // coefficients above one act as one
    function automatic logic [COEF_W-1:0] clamp_one(input logic [COEF_W-1:0] c);
        clamp_one = (c > spm_pkg::Q24_ONE) ? spm_pkg::Q24_ONE : c;
    endfunction

    // square sum saturates at all ones
    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] sum,
                                                 input logic [2*LVL_W-1:0] sq);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + (SUM_W+1)'(sq);
        add_sat = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    spm_divsqrt #(
        .DIV_W (CNT_W)
    ) u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ds_start),
        .dividend (ds_dividend),
        .divisor  (frames_reg),
        .result   (ds_result)
    );

    assign s_tready = (state_reg == spm_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign ds_dividend = ch_reg ? sum_r_reg : sum_l_reg;
    assign acc_sum     = {1'b0, acc_reg} + {1'b0, prod_reg[ACC_W-1:0]};
    assign decayed     = prod_reg[Q_FRAC+LVL_W-1:Q_FRAC];
    assign prod_next   = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        state_next      = state_reg;
        mag_l_next      = mag_l_reg;
        mag_r_next      = mag_r_reg;
        last_next       = last_reg;
        ch_next         = ch_reg;
        blk_pk_l_next   = blk_pk_l_reg;
        blk_pk_r_next   = blk_pk_r_reg;
        sum_l_next      = sum_l_reg;
        sum_r_next      = sum_r_reg;
        frames_next     = frames_reg;
        dpow_next       = dpow_reg;
        rpow_next       = rpow_reg;
        held_l_next     = held_l_reg;
        held_r_next     = held_r_reg;
        smooth_l_next   = smooth_l_reg;
        smooth_r_next   = smooth_r_reg;
        rms_coeff_next  = rms_coeff_reg;
        peak_decay_next = peak_decay_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mul_a           = '0;
        mul_b           = '0;
        ds_start        = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                spm_pkg::CFG_RMS_COEFF:  rms_coeff_next  = cfg_data;
                spm_pkg::CFG_PEAK_DECAY: peak_decay_next = cfg_data;
                default:                 rms_coeff_next  = rms_coeff_reg;
            endcase
        end

        // result word taken downstream
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            spm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mag_l_next = magnitude(s_tdata[SMP_W-1:0]);
                    mag_r_next = magnitude(s_tdata[2*SMP_W-1:SMP_W]);
                    last_next  = s_tlast;
                    state_next = spm_pkg::ST_SQ_L;
                end
            end
            spm_pkg::ST_SQ_L:
            begin
                mul_a = COEF_W'(mag_l_reg);
                mul_b = COEF_W'(mag_l_reg);
                if (mag_l_reg > blk_pk_l_reg)
                begin
                    blk_pk_l_next = mag_l_reg;
                end
                if (mag_r_reg > blk_pk_r_reg)
                begin
                    blk_pk_r_next = mag_r_reg;
                end
                frames_next = frames_reg + CNT_W'(1);
                state_next  = spm_pkg::ST_SQ_R;
            end
            spm_pkg::ST_SQ_R:
            begin
                mul_a      = COEF_W'(mag_r_reg);
                mul_b      = COEF_W'(mag_r_reg);
                sum_l_next = add_sat(sum_l_reg, prod_reg[2*LVL_W-1:0]);
                state_next = spm_pkg::ST_PW_D;
            end
            spm_pkg::ST_PW_D:
            begin
                mul_a      = dpow_reg;
                mul_b      = clamp_one(peak_decay_reg);
                sum_r_next = add_sat(sum_r_reg, prod_reg[2*LVL_W-1:0]);
                state_next = spm_pkg::ST_PW_R;
            end
            spm_pkg::ST_PW_R:
            begin
                mul_a      = rpow_reg;
                mul_b      = clamp_one(rms_coeff_reg);
                dpow_next  = prod_reg[Q_FRAC+COEF_W-1:Q_FRAC];
                state_next = spm_pkg::ST_CHECK;
            end
            spm_pkg::ST_CHECK:
            begin
                rpow_next = prod_reg[Q_FRAC+COEF_W-1:Q_FRAC];
                // block closes on its flag or when it is full
                if (last_reg || (frames_reg == CNT_W'(BLOCK_MAX)))
                begin
                    state_next = spm_pkg::ST_PK_L;
                end
                else
                begin
                    state_next = spm_pkg::ST_IDLE;
                end
            end
            spm_pkg::ST_PK_L:
            begin
                mul_a      = COEF_W'(held_l_reg);
                mul_b      = dpow_reg;
                state_next = spm_pkg::ST_PK_R;
            end
            spm_pkg::ST_PK_R:
            begin
                mul_a       = COEF_W'(held_r_reg);
                mul_b       = dpow_reg;
                held_l_next = (blk_pk_l_reg > decayed) ? blk_pk_l_reg : decayed;
                state_next  = spm_pkg::ST_PK_DONE;
            end
            spm_pkg::ST_PK_DONE:
            begin
                held_r_next = (blk_pk_r_reg > decayed) ? blk_pk_r_reg : decayed;
                ch_next     = 1'b0;
                state_next  = spm_pkg::ST_RMS_GO;
            end
            spm_pkg::ST_RMS_GO:
            begin
                ds_start   = 1'b1;
                state_next = spm_pkg::ST_RMS_WAIT;
            end
            spm_pkg::ST_RMS_WAIT:
            begin
                if (ds_result.done)
                begin
                    state_next = spm_pkg::ST_RMS_MA;
                end
            end
            spm_pkg::ST_RMS_MA:
            begin
                mul_a      = COEF_W'(ch_reg ? smooth_r_reg : smooth_l_reg);
                mul_b      = rpow_reg;
                state_next = spm_pkg::ST_RMS_MB;
            end
            spm_pkg::ST_RMS_MB:
            begin
                acc_next   = prod_reg[ACC_W-1:0];
                mul_a      = COEF_W'(ds_result.root);
                mul_b      = spm_pkg::Q24_ONE - rpow_reg;
                state_next = spm_pkg::ST_RMS_SUM;
            end
            spm_pkg::ST_RMS_SUM:
            begin
                if (ch_reg)
                begin
                    smooth_r_next = acc_sum[Q_FRAC+LVL_W-1:Q_FRAC];
                    state_next    = spm_pkg::ST_OUT;
                end
                else
                begin
                    smooth_l_next = acc_sum[Q_FRAC+LVL_W-1:Q_FRAC];
                    ch_next       = 1'b1;
                    state_next    = spm_pkg::ST_RMS_GO;
                end
            end
            spm_pkg::ST_OUT:
            begin
                // wait for a free output register, then open a new block
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {smooth_r_reg, smooth_l_reg, held_r_reg, held_l_reg};
                    blk_pk_l_next  = '0;
                    blk_pk_r_next  = '0;
                    sum_l_next     = '0;
                    sum_r_next     = '0;
                    frames_next    = '0;
                    dpow_next      = spm_pkg::Q24_ONE;
                    rpow_next      = spm_pkg::Q24_ONE;
                    state_next     = spm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg         <= 1'b0;
            blk_pk_l_reg   <= '0;
            blk_pk_r_reg   <= '0;
            sum_l_reg      <= '0;
            sum_r_reg      <= '0;
            frames_reg     <= '0;
            dpow_reg       <= spm_pkg::Q24_ONE;
            rpow_reg       <= spm_pkg::Q24_ONE;
            held_l_reg     <= '0;
            held_r_reg     <= '0;
            smooth_l_reg   <= '0;
            smooth_r_reg   <= '0;
            rms_coeff_reg  <= spm_pkg::RMS_COEFF_RST;
            peak_decay_reg <= spm_pkg::PEAK_DECAY_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ch_reg         <= ch_next;
            blk_pk_l_reg   <= blk_pk_l_next;
            blk_pk_r_reg   <= blk_pk_r_next;
            sum_l_reg      <= sum_l_next;
            sum_r_reg      <= sum_r_next;
            frames_reg     <= frames_next;
            dpow_reg       <= dpow_next;
            rpow_reg       <= rpow_next;
            held_l_reg     <= held_l_next;
            held_r_reg     <= held_r_next;
            smooth_l_reg   <= smooth_l_next;
            smooth_r_reg   <= smooth_r_next;
            rms_coeff_reg  <= rms_coeff_next;
            peak_decay_reg <= peak_decay_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_l_reg    <= mag_l_next;
        mag_r_reg    <= mag_r_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

FILE: rtl/spm_checker.sv
// port-level assertions for the stereo peak and rms meter, with its bind
`timescale 1ns / 1ps
`default_nettype none
module spm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // no result word valid while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result word valid during reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // a frame keeps the meter busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("frame accepted on consecutive cycles");

    // a new result is loaded only from the block close step
    a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result word appeared while the meter was idle");

    // every level is a magnitude no larger than one
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] <= 16'd32768) && (m_tdata[31:16] <= 16'd32768)
                  && (m_tdata[47:32] <= 16'd32768) && (m_tdata[63:48] <= 16'd32768))
        else $error("level above full scale");

endmodule

bind stereo_peak_rms_meter spm_checker u_spm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
